// ===== rtl/ljfs_pkg.sv =====
// Shared constants and types for the Lennard-Jones force sum block.
`timescale 1ns / 1ps

package ljfs_pkg;

   localparam int unsigned DATA_W        = 64;
   localparam logic [63:0] SAT_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;

   // divider retires this many quotient bits per cycle
   localparam int unsigned DIV_STEP_BITS = 4;
   localparam int unsigned DIV_ITERS     = DATA_W / DIV_STEP_BITS;
   localparam int unsigned DIV_CNT_W     = $clog2(DIV_ITERS);

   // multiplier: four 32x32 partial products, one per cycle, then the final add
   localparam int unsigned MUL_CNT_W     = 3;
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = 3'd5;

   // register reset values
   localparam logic [31:0] PROBE_RESET   = 32'd0;
   localparam logic [30:0] CUTOFF_RESET  = 31'd655360;
   localparam logic [30:0] DEPTH_RESET   = 31'd327680;
   localparam logic [30:0] RMIN_RESET    = 31'd6554;

   typedef enum logic [1:0] {
      CSR_PROBE  = 2'd0,
      CSR_CUTOFF = 2'd1,
      CSR_DEPTH  = 2'd2,
      CSR_RMIN   = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/lennard_jones_force_sum_1d.sv =====
// Lennard-Jones pair force sum over a stream of particle positions, shared mul and div units.
`timescale 1ns / 1ps

// Channel   Ports                              Contents
// req       req_tvalid/tready/tdata/tlast      particle position, last-of-set mark
// rsp       rsp_tvalid/tready/tdata/tuser      total force, saturation flag
// csr       csr_we/csr_index/csr_wdata         probe, cutoff, epsilon, r_m
//
// A particle inside the cutoff runs two radix-16 divisions and five multiplies on the
// shared 32x32 multiplier, plus setup, accumulate and finish; when the force divide
// clamps, the second division is skipped. A particle outside the cutoff, or at the
// probe, goes from setup straight to finish.
// Synchronous active-high reset clears the sum, the flag and the registers to defaults.
// A last item waits in its finish cycle while the previous result is still untaken.
module lennard_jones_force_sum_1d
   import ljfs_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] particle_position
   input  logic        req_tlast,   // last_particle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] total_force
   output logic        rsp_tuser,   // saturated
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_DIV_S, S_MUL_S2, S_MUL_S4, S_MUL_S6,
      S_MUL_S12, S_MUL_M, S_DIV_F, S_ACC, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] probe_ff, probe_in;
   logic [30:0]        cutoff_ff, cutoff_in;
   logic [30:0]        depth_ff, depth_in;
   logic [30:0]        rmin_ff, rmin_in;

   logic signed [32:0] r_ff, r_in;
   logic               last_ff, last_in;
   logic [32:0]        a_ff, a_in;
   logic               rneg_ff, rneg_in;

   logic [33:0]          rem_ff, rem_in;
   logic [63:0]          lo_ff, lo_in;
   logic [63:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;

   logic [63:0]          mx_ff, mx_in, my_ff, my_in;
   logic [63:0]          pp_ff, pp_in;
   logic [1:0]           psh_ff, psh_in;
   logic [127:0]         prod_ff, prod_in;
   logic [MUL_CNT_W-1:0] mcnt_ff, mcnt_in;

   logic [63:0]        s2_ff, s2_in, s6_ff, s6_in, fmag_ff, fmag_in;
   logic               dneg_ff, dneg_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               flag_ff, flag_in;

   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_sat_ff, rsp_sat_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [33:0]  drem, dtrial;
   logic [63:0]  dlo, dquo, dval;
   logic         dsat, ddone;
   logic [31:0]  px, py;
   logic [127:0] pp_wide;
   logic [63:0]  qval;
   logic         qsat, mdone;
   logic [32:0]  a_abs;
   logic [63:0]  w12, dmag;
   logic         s12_lt;
   logic [33:0]  mhi;
   logic [64:0]  accx, fx, sum65;
   logic         tneg, out_free;

   // shared divider: DIV_STEP_BITS restoring steps per cycle
   always_comb begin
      drem = rem_ff;
      dlo  = lo_ff;
      dquo = quo_ff;
      dtrial = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         dtrial = {drem[32:0], dlo[63]};
         dlo    = {dlo[62:0], 1'b0};
         if (dtrial >= {1'b0, a_ff}) begin
            drem = dtrial - {1'b0, a_ff};
            dquo = {dquo[62:0], 1'b1};
         end else begin
            drem = dtrial;
            dquo = {dquo[62:0], 1'b0};
         end
      end
      dsat  = dquo[63];
      dval  = dsat ? SAT_MAX : dquo;
      ddone = (dcnt_ff == DIV_CNT_W'(DIV_ITERS - 1));
   end

   // shared multiplier: partial product select and Q-format result
   always_comb begin
      case (mcnt_ff)
         3'd0:    begin px = mx_ff[31:0];  py = my_ff[31:0];  end
         3'd1:    begin px = mx_ff[31:0];  py = my_ff[63:32]; end
         3'd2:    begin px = mx_ff[63:32]; py = my_ff[31:0];  end
         default: begin px = mx_ff[63:32]; py = my_ff[63:32]; end
      endcase
      pp_wide = {64'd0, pp_ff} << (7'd32 * {5'd0, psh_ff});
      qsat    = |prod_ff[127:FRAC_BITS+63];
      qval    = qsat ? SAT_MAX : {1'b0, prod_ff[FRAC_BITS+62:FRAC_BITS]};
      mdone   = (mcnt_ff == MUL_LAST);
   end

   always_comb begin
      a_abs    = r_ff[32] ? 33'(-r_ff) : 33'(r_ff);
      w12      = ({33'd0, depth_ff} << 3) + ({33'd0, depth_ff} << 2);
      s12_lt   = (qval < s6_ff);
      dmag     = s12_lt ? (s6_ff - qval) : (qval - s6_ff);
      mhi      = 34'(qval >> (64 - FRAC_BITS));
      tneg     = dneg_ff ^ rneg_ff;
      accx     = {acc_ff[63], acc_ff};
      fx       = {1'b0, fmag_ff};
      sum65    = tneg ? (accx - fx) : (accx + fx);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      probe_in     = probe_ff;
      cutoff_in    = cutoff_ff;
      depth_in     = depth_ff;
      rmin_in      = rmin_ff;
      r_in         = r_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      rneg_in      = rneg_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      pp_in        = 64'(px) * 64'(py);
      psh_in       = (mcnt_ff == 3'd0) ? 2'd0 : ((mcnt_ff == 3'd3) ? 2'd2 : 2'd1);
      prod_in      = (mcnt_ff == 3'd0) ? '0 : (prod_ff + pp_wide);
      mcnt_in      = '0;
      s2_in        = s2_ff;
      s6_in        = s6_ff;
      fmag_in      = fmag_ff;
      dneg_in      = dneg_ff;
      acc_in       = acc_ff;
      flag_in      = flag_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_index)
            CSR_PROBE:  probe_in  = csr_wdata;
            CSR_CUTOFF: cutoff_in = csr_wdata[30:0];
            CSR_DEPTH:  depth_in  = csr_wdata[30:0];
            CSR_RMIN:   rmin_in   = csr_wdata[30:0];
            default:    ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               r_in     = {probe_ff[31], probe_ff} - {req_tdata[31], req_tdata};
               last_in  = req_tlast;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            a_in    = a_abs;
            rneg_in = r_ff[32];
            if (a_abs >= {2'b00, cutoff_ff}) begin
               state_in = S_FINISH;
            end else if (a_abs == '0) begin
               flag_in  = 1'b1;
               state_in = S_FINISH;
            end else begin
               // r_m / |r| in Q format
               rem_in   = '0;
               lo_in    = {33'd0, rmin_ff} << FRAC_BITS;
               quo_in   = '0;
               dcnt_in  = '0;
               state_in = S_DIV_S;
            end
         end
         S_DIV_S, S_DIV_F: begin
            rem_in  = drem;
            lo_in   = dlo;
            quo_in  = dquo;
            dcnt_in = dcnt_ff + 1'b1;
            if (ddone) begin
               flag_in = flag_ff | dsat;
               if (state_ff == S_DIV_S) begin
                  mx_in    = dval;
                  my_in    = dval;
                  state_in = S_MUL_S2;
               end else begin
                  fmag_in  = dval;
                  state_in = S_ACC;
               end
            end
         end
         S_MUL_S2, S_MUL_S4, S_MUL_S6, S_MUL_S12, S_MUL_M: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mdone) begin
               mcnt_in = '0;
               flag_in = flag_ff | qsat;
               case (state_ff)
                  S_MUL_S2: begin
                     s2_in    = qval;
                     mx_in    = qval;
                     my_in    = qval;
                     state_in = S_MUL_S4;
                  end
                  S_MUL_S4: begin
                     mx_in    = qval;
                     my_in    = s2_ff;
                     state_in = S_MUL_S6;
                  end
                  S_MUL_S6: begin
                     s6_in    = qval;
                     mx_in    = qval;
                     my_in    = qval;
                     state_in = S_MUL_S12;
                  end
                  S_MUL_S12: begin
                     dneg_in  = s12_lt;
                     mx_in    = w12;
                     my_in    = dmag;
                     state_in = S_MUL_M;
                  end
                  default: begin
                     // force = m / |r|; quotient overflow is known from the high part
                     if (mhi >= {1'b0, a_ff}) begin
                        flag_in  = 1'b1;
                        fmag_in  = SAT_MAX;
                        state_in = S_ACC;
                     end else begin
                        rem_in   = mhi;
                        lo_in    = qval << FRAC_BITS;
                        quo_in   = '0;
                        dcnt_in  = '0;
                        state_in = S_DIV_F;
                     end
                  end
               endcase
            end
         end
         S_ACC: begin
            if (sum65[64] != sum65[63]) begin
               flag_in = 1'b1;
               acc_in  = sum65[64] ? {1'b1, 63'd0} : SAT_MAX;
            end else begin
               acc_in  = sum65[63:0];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_data_in  = acc_ff;
               rsp_sat_in   = flag_ff;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               flag_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         probe_ff     <= PROBE_RESET;
         cutoff_ff    <= CUTOFF_RESET;
         depth_ff     <= DEPTH_RESET;
         rmin_ff      <= RMIN_RESET;
         acc_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mcnt_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         cutoff_ff    <= cutoff_in;
         depth_ff     <= depth_in;
         rmin_ff      <= rmin_in;
         acc_ff       <= acc_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff      <= mcnt_in;
         dcnt_ff      <= dcnt_in;
      end
      r_ff        <= r_in;
      last_ff     <= last_in;
      a_ff        <= a_in;
      rneg_ff     <= rneg_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      quo_ff      <= quo_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      pp_ff       <= pp_in;
      psh_ff      <= psh_in;
      prod_ff     <= prod_in;
      s2_ff       <= s2_in;
      s6_ff       <= s6_in;
      fmag_ff     <= fmag_in;
      dneg_ff     <= dneg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // a new result only comes out of the finish cycle of a last item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_FINISH) && $past(last_ff))
      else $error("result raised outside the finish of a last item");

   // sum and flag start from zero after a result is handed over
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && last_ff && out_free |=> (acc_ff == '0) && !flag_ff)
      else $error("accumulator not cleared after result");

   // restoring divider keeps its remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_S) || (state_ff == S_DIV_F) |-> (rem_ff < {1'b0, a_ff}))
      else $error("divider remainder out of range");

   // no arithmetic is started for a particle sitting at the probe
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_S) || (state_ff == S_DIV_F) || (state_ff == S_ACC)
      |-> (a_ff != '0))
      else $error("term evaluated with zero distance");

   // a result waiting on the output is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("pending result overwritten");

endmodule
